// ----- rtl/core/srks_pkg.sv -----
// ----------------------------------------------------------------------------
// srks_pkg : shared types and constants of the shift register key scanner
// Operation codes, register indexes, widths and the lane result record.
// ----------------------------------------------------------------------------
package srks_pkg;

    localparam int KEY_W    = 6;
    localparam int COUNT_W  = 8;
    localparam int LEVEL_W  = 3;
    localparam int IDLE_W   = 8;
    localparam int PHASE_W  = 3;
    localparam int BITIDX_W = 3;
    localparam int CFG_W    = 8;

    localparam logic [COUNT_W-1:0] WRAP_COUNT = 8'hFF;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_READ = 2'd1,
        OP_WAKE = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic {
        CFG_BRIGHTNESS = 1'b0,
        CFG_IDLE_LIMIT = 1'b1
    } cfg_idx_t;

    // scan phases with a fixed meaning
    localparam logic [PHASE_W-1:0] PH_RESET_ON  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_RESET_OFF = 3'd1;
    localparam logic [PHASE_W-1:0] PH_FIRST_SAMPLE = 3'd3;

    // what one sampling lane found for its key bit
    typedef struct packed {
        logic [KEY_W-1:0] clr_mask;
        logic [KEY_W-1:0] set_mask;
        logic [KEY_W-1:0] press_mask;
    } lane_res_t;

    // backlight and idle timer update
    typedef struct packed {
        logic              line;
        logic              forced_off;
        logic [IDLE_W-1:0] idle_periods;
        logic              leds_clear;
    } light_res_t;

endpackage

// ----- rtl/core/shift_register_key_scanner.sv -----
// ----------------------------------------------------------------------------
// shift_register_key_scanner : tick driven key scanner with backlight pwm
// Sequences an external key shift register, latches presses, drives the
// backlight and clears the leds after an idle time.
// ----------------------------------------------------------------------------
//  channel   ports                                          direction
//  ------    ---------------------------------------------  ---------
//  input     s_valid s_ready s_operation s_channel_a/_b      in
//  result    m_valid m_ready m_backlight_enable ...          out
//  config    cfg_we cfg_index cfg_data                       in
//
//  one item per clock while s_ready is high; result in output register next cycle
//  all state updates in the single cycle of the accepting transfer
//  s_ready is high while the output register is empty or being taken
//  aresetn is synchronous and active low; no clearing pass is needed
// ----------------------------------------------------------------------------
module shift_register_key_scanner (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [srks_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_operation,
    input  logic                          s_channel_a,
    input  logic                          s_channel_b,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_backlight_enable,
    output logic                          m_scan_reset,
    output logic                          m_scan_clock,
    output logic [srks_pkg::KEY_W-1:0]    m_held_keys,
    output logic [srks_pkg::KEY_W-1:0]    m_read_keys,
    output logic                          m_leds_clear
);

    logic [srks_pkg::LEVEL_W-1:0]  brightness_reg;
    logic [srks_pkg::IDLE_W-1:0]   idle_limit_reg;
    logic [srks_pkg::COUNT_W-1:0]  tick_count_reg, tick_count_next;
    logic [srks_pkg::KEY_W-1:0]    key_levels_reg, key_levels_next;
    logic [srks_pkg::KEY_W-1:0]    pending_reg, pending_next;
    logic [srks_pkg::IDLE_W-1:0]   idle_periods_reg;
    logic                          forced_off_reg;
    logic                          reset_line_reg, reset_line_next;
    logic                          clock_line_reg, clock_line_next;
    logic                          light_line_reg;
    logic                          m_valid_reg;
    logic                          out_light_reg, out_reset_reg, out_clock_reg;
    logic [srks_pkg::KEY_W-1:0]    out_held_reg, out_read_reg, read_next;
    logic                          out_ledclr_reg;

    srks_pkg::op_t                 op;
    logic                          accept, tick, sample_tick, cmd_wake;
    logic [srks_pkg::PHASE_W-1:0]  phase;
    logic [srks_pkg::BITIDX_W-1:0] bit_a, bit_b;
    srks_pkg::lane_res_t           lane_a, lane_b;
    srks_pkg::light_res_t          light;
    logic [srks_pkg::KEY_W-1:0]    merged_levels, merged_pending;
    logic                          key_wake;

    assign op      = srks_pkg::op_t'(s_operation);
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign tick    = accept && (op == srks_pkg::OP_TICK);
    assign cmd_wake = accept && (op == srks_pkg::OP_WAKE);

    // scan phase is tick count bits [3:1]; the scan lines act on even counts only
    assign phase       = tick_count_reg[srks_pkg::PHASE_W:1];
    assign sample_tick = tick && !tick_count_reg[0] && phase[0] &&
                         (phase >= srks_pkg::PH_FIRST_SAMPLE);
    assign bit_a = phase - srks_pkg::PH_FIRST_SAMPLE;
    assign bit_b = bit_a + 1'b1;

    srks_key_lane u_lane_a (
        .enable     (sample_tick),
        .bit_index  (bit_a),
        .sample     (s_channel_a),
        .key_levels (key_levels_reg),
        .result     (lane_a)
    );

    srks_key_lane u_lane_b (
        .enable     (sample_tick),
        .bit_index  (bit_b),
        .sample     (s_channel_b),
        .key_levels (key_levels_reg),
        .result     (lane_b)
    );

    srks_key_merge u_merge (
        .lane_a          (lane_a),
        .lane_b          (lane_b),
        .key_levels      (key_levels_reg),
        .pending         (pending_reg),
        .key_levels_next (merged_levels),
        .pending_next    (merged_pending),
        .wake            (key_wake)
    );

    srks_backlight u_backlight (
        .tick         (tick),
        .wake         (key_wake || cmd_wake),
        .tick_count   (tick_count_reg),
        .brightness   (brightness_reg),
        .idle_limit   (idle_limit_reg),
        .forced_off   (forced_off_reg),
        .idle_periods (idle_periods_reg),
        .line         (light_line_reg),
        .result       (light)
    );

    always_comb begin
        tick_count_next = tick_count_reg;
        key_levels_next = merged_levels;
        pending_next    = merged_pending;
        reset_line_next = reset_line_reg;
        clock_line_next = clock_line_reg;
        read_next       = '0;
        if (tick) begin
            tick_count_next = tick_count_reg + 1'b1;
            if (!tick_count_reg[0]) begin
                if (phase == srks_pkg::PH_RESET_ON) begin
                    reset_line_next = 1'b1;
                end else if (phase == srks_pkg::PH_RESET_OFF) begin
                    reset_line_next = 1'b0;
                end else begin
                    clock_line_next = !phase[0];
                end
            end
        end
        if (accept && op == srks_pkg::OP_READ) begin
            read_next    = pending_reg;
            pending_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg   <= '0;
            idle_limit_reg   <= 8'd16;
            tick_count_reg   <= '0;
            key_levels_reg   <= '0;
            pending_reg      <= '0;
            idle_periods_reg <= '0;
            forced_off_reg   <= 1'b0;
            reset_line_reg   <= 1'b0;
            clock_line_reg   <= 1'b0;
            light_line_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (srks_pkg::cfg_idx_t'(cfg_index))
                    srks_pkg::CFG_BRIGHTNESS: brightness_reg <= cfg_data[srks_pkg::LEVEL_W-1:0];
                    srks_pkg::CFG_IDLE_LIMIT: idle_limit_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                tick_count_reg   <= tick_count_next;
                key_levels_reg   <= key_levels_next;
                pending_reg      <= pending_next;
                idle_periods_reg <= light.idle_periods;
                forced_off_reg   <= light.forced_off;
                reset_line_reg   <= reset_line_next;
                clock_line_reg   <= clock_line_next;
                light_line_reg   <= light.line;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded on each input transfer
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_light_reg  <= light.line;
            out_reset_reg  <= reset_line_next;
            out_clock_reg  <= clock_line_next;
            out_held_reg   <= key_levels_next;
            out_read_reg   <= read_next;
            out_ledclr_reg <= light.leds_clear;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_backlight_enable = out_light_reg;
    assign m_scan_reset       = out_reset_reg;
    assign m_scan_clock       = out_clock_reg;
    assign m_held_keys        = out_held_reg;
    assign m_read_keys        = out_read_reg;
    assign m_leds_clear       = out_ledclr_reg;

endmodule

// ----- rtl/core/srks_key_lane.sv -----
// ----------------------------------------------------------------------------
// srks_key_lane : one key sampling lane
// Takes one data pin into its key bit and flags a fresh press.
// ----------------------------------------------------------------------------
module srks_key_lane (
    input  logic                           enable,
    input  logic [srks_pkg::BITIDX_W-1:0]  bit_index,
    input  logic                           sample,
    input  logic [srks_pkg::KEY_W-1:0]     key_levels,
    output srks_pkg::lane_res_t            result
);

    logic [srks_pkg::KEY_W-1:0] sel;
    logic                       was_held;

    always_comb begin
        sel = enable ? srks_pkg::KEY_W'(1'b1) << bit_index : '0;
        was_held = |(key_levels & sel);
        result.clr_mask   = sel;
        result.set_mask   = sample ? sel : '0;
        // rising key level only
        result.press_mask = (sample && !was_held) ? sel : '0;
    end

endmodule

// ----- rtl/core/srks_key_merge.sv -----
// ----------------------------------------------------------------------------
// srks_key_merge : merge of the two sampling lanes
// Combines lane results into new key levels, pending presses and wake.
// ----------------------------------------------------------------------------
module srks_key_merge (
    input  srks_pkg::lane_res_t            lane_a,
    input  srks_pkg::lane_res_t            lane_b,
    input  logic [srks_pkg::KEY_W-1:0]     key_levels,
    input  logic [srks_pkg::KEY_W-1:0]     pending,
    output logic [srks_pkg::KEY_W-1:0]     key_levels_next,
    output logic [srks_pkg::KEY_W-1:0]     pending_next,
    output logic                           wake
);

    logic [srks_pkg::KEY_W-1:0] press_all;

    always_comb begin
        press_all       = lane_a.press_mask | lane_b.press_mask;
        key_levels_next = (key_levels & ~(lane_a.clr_mask | lane_b.clr_mask))
                        | lane_a.set_mask | lane_b.set_mask;
        pending_next    = pending | press_all;
        wake            = |press_all;
    end

endmodule

// ----- rtl/core/srks_backlight.sv -----
// ----------------------------------------------------------------------------
// srks_backlight : backlight pwm and idle turn-off
// Four phase pwm from the tick count, idle period count on count wrap.
// ----------------------------------------------------------------------------
module srks_backlight (
    input  logic                          tick,
    input  logic                          wake,
    input  logic [srks_pkg::COUNT_W-1:0]  tick_count,
    input  logic [srks_pkg::LEVEL_W-1:0]  brightness,
    input  logic [srks_pkg::IDLE_W-1:0]   idle_limit,
    input  logic                          forced_off,
    input  logic [srks_pkg::IDLE_W-1:0]   idle_periods,
    input  logic                          line,
    output srks_pkg::light_res_t          result
);

    logic pwm_on;

    always_comb begin
        pwm_on = !forced_off &&
                 ({1'b0, tick_count[1:0]} >= brightness);
        result.line         = line;
        result.forced_off   = forced_off;
        result.idle_periods = idle_periods;
        result.leds_clear   = 1'b0;
        if (tick) begin
            result.line = pwm_on;
            if (tick_count == srks_pkg::WRAP_COUNT) begin
                if (idle_periods >= idle_limit) begin
                    result.leds_clear = 1'b1;
                    result.forced_off = 1'b1;
                end else begin
                    result.idle_periods = idle_periods + 1'b1;
                end
            end
        end
        // key press or wake command restarts the idle timer
        if (wake) begin
            result.forced_off   = 1'b0;
            result.idle_periods = '0;
        end
    end

endmodule

// ----- verif/shift_register_key_scanner_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shift_register_key_scanner_test : self-checking bench for the key scanner
// Feeds ticks, reads, wakes and unused operations through the valid/ready
// input, tracks the scan sequence, key latches and backlight idle timer in a
// local predictor and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module shift_register_key_scanner_test;

    import srks_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 265;

    typedef struct packed {
        op_t  op;
        logic a;
        logic b;
    } scan_item_t;

    typedef struct packed {
        logic             backlight;
        logic             scan_reset;
        logic             scan_clock;
        logic [KEY_W-1:0] held_keys;
        logic [KEY_W-1:0] read_keys;
        logic             leds_clear;
    } scan_result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    logic              cfg_index = 1'b0;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_operation = 2'd0;
    logic              s_channel_a = 1'b0;
    logic              s_channel_b = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_backlight_enable;
    logic              m_scan_reset;
    logic              m_scan_clock;
    logic [KEY_W-1:0]  m_held_keys;
    logic [KEY_W-1:0]  m_read_keys;
    logic              m_leds_clear;

    shift_register_key_scanner dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_channel_a        (s_channel_a),
        .s_channel_b        (s_channel_b),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_backlight_enable (m_backlight_enable),
        .m_scan_reset       (m_scan_reset),
        .m_scan_clock       (m_scan_clock),
        .m_held_keys        (m_held_keys),
        .m_read_keys        (m_read_keys),
        .m_leds_clear       (m_leds_clear)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // scanner state as the block should hold it
    logic [LEVEL_W-1:0] level_cfg = '0;
    logic [IDLE_W-1:0]  idle_cfg = 8'd16;
    logic [COUNT_W-1:0] count_q = '0;
    logic [KEY_W-1:0]   keys_q = '0;
    logic [KEY_W-1:0]   presses_q = '0;
    logic [IDLE_W-1:0]  idle_q = '0;
    logic               dark_q = 1'b0;
    logic               rst_line_q = 1'b0;
    logic               clk_line_q = 1'b0;
    logic               light_q = 1'b0;

    scan_item_t   pending_items[$];
    scan_result_t expected_scans[$];
    logic [COUNT_W-1:0] gen_count = '0;
    int queued_count = 0;
    int accepted_count = 0;
    int taken_count = 0;
    int fail_count = 0;
    int send_gap = 0;
    int tx_burst = 0;
    int stall_left = 0;
    int rx_burst = 0;
    int hold_left = 0;
    bit held_off = 1'b0;
    int quiet_cycles = 0;

    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 3) begin
            burst = $urandom_range(30, 150);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void latch_key(int pos, logic level);
        logic [KEY_W-1:0] mask;
        mask = KEY_W'(1) << pos;
        if (level) begin
            if ((keys_q & mask) == '0) begin
                presses_q = presses_q | mask;
                keys_q    = keys_q | mask;
                dark_q    = 1'b0;
                idle_q    = '0;
            end
        end else begin
            keys_q = keys_q & ~mask;
        end
    endfunction

    function automatic scan_result_t advance_scanner(op_t op, logic a, logic b);
        scan_result_t r;
        logic [COUNT_W-1:0] t;
        logic [PHASE_W-1:0] ph;
        r = '0;
        case (op)
            OP_TICK: begin
                t = count_q;
                count_q = t + 8'd1;
                // pwm uses the count before the increment
                light_q = !dark_q && ({1'b0, t[1:0]} >= level_cfg);
                if (t == WRAP_COUNT) begin
                    if (idle_q >= idle_cfg) begin
                        r.leds_clear = 1'b1;
                        dark_q = 1'b1;
                    end else begin
                        idle_q = idle_q + 8'd1;
                    end
                end
                if (!t[0]) begin
                    ph = t[3:1];
                    if (ph == PH_RESET_ON) begin
                        rst_line_q = 1'b1;
                    end else if (ph == PH_RESET_OFF) begin
                        rst_line_q = 1'b0;
                    end else if (!ph[0]) begin
                        clk_line_q = 1'b1;
                    end else begin
                        clk_line_q = 1'b0;
                        latch_key(int'(ph) - int'(PH_FIRST_SAMPLE), a);
                        latch_key(int'(ph) - int'(PH_FIRST_SAMPLE) + 1, b);
                    end
                end
            end
            OP_READ: begin
                r.read_keys = presses_q;
                presses_q = '0;
            end
            OP_WAKE: begin
                dark_q = 1'b0;
                idle_q = '0;
            end
            default: ;
        endcase
        r.backlight  = light_q;
        r.scan_reset = rst_line_q;
        r.scan_clock = clk_line_q;
        r.held_keys  = keys_q;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [KEY_W-1:0] want,
                                          logic [KEY_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // input side
    always @(posedge aclk) begin : driver
        scan_item_t item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_scans.push_back(
                    advance_scanner(op_t'(s_operation), s_channel_a, s_channel_b));
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    item = pending_items.pop_front();
                    s_valid     <= 1'b1;
                    s_operation <= item.op;
                    s_channel_a <= item.a;
                    s_channel_b <= item.b;
                    send_gap = pick_gap(tx_burst);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin : monitor
        scan_result_t want;
        int gap;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                taken_count++;
                if (expected_scans.size() == 0) begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end else begin
                    want = expected_scans.pop_front();
                    compare_field("backlight_enable", KEY_W'(want.backlight),
                                  KEY_W'(m_backlight_enable));
                    compare_field("scan_reset", KEY_W'(want.scan_reset),
                                  KEY_W'(m_scan_reset));
                    compare_field("scan_clock", KEY_W'(want.scan_clock),
                                  KEY_W'(m_scan_clock));
                    compare_field("held_keys", want.held_keys, m_held_keys);
                    compare_field("read_keys", want.read_keys, m_read_keys);
                    compare_field("leds_clear", KEY_W'(want.leds_clear),
                                  KEY_W'(m_leds_clear));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!held_off && taken_count >= 400) begin
                // long hold-off so the block fills and stalls its input
                held_off = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                gap = pick_gap(rx_burst);
                m_ready <= (gap == 0);
                stall_left = (gap == 0) ? 0 : gap - 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("shift_register_key_scanner_test NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_item(input op_t op, input logic a, input logic b);
        scan_item_t item;
        item.op = op;
        item.a  = a;
        item.b  = b;
        pending_items.push_back(item);
        queued_count++;
        if (op == OP_TICK) gen_count = gen_count + 8'd1;
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (queued_count != accepted_count || expected_scans.size() != 0);
    endtask

    task automatic write_settings(input logic [LEVEL_W-1:0] level,
                                  input logic [IDLE_W-1:0] limit);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BRIGHTNESS;
        cfg_data  <= CFG_W'(level);
        @(posedge aclk);
        level_cfg = level;
        cfg_index <= CFG_IDLE_LIMIT;
        cfg_data  <= limit;
        @(posedge aclk);
        idle_cfg = limit;
        cfg_we <= 1'b0;
    endtask

    // mostly held key patterns fed on the sampling ticks, with noisy stretches
    task automatic queue_random(input int count);
        int i;
        int seg_left;
        int r;
        bit tidy;
        logic [KEY_W-1:0] pattern;
        logic [PHASE_W-1:0] ph;
        op_t op;
        logic a;
        logic b;
        seg_left = 0;
        tidy = 1'b1;
        pattern = '0;
        for (i = 0; i < count; i++) begin
            if (seg_left == 0) begin
                tidy = ($urandom_range(99) < 80);
                seg_left = tidy ? $urandom_range(16, 400) : $urandom_range(1, 24);
                pattern = ($urandom_range(3) == 0) ? '0 : KEY_W'($urandom);
            end
            seg_left--;
            r = $urandom_range(99);
            if (tidy) begin
                if (r < 90) op = OP_TICK;
                else if (r < 98) op = OP_READ;
                else if (r < 99) op = OP_WAKE;
                else op = OP_NONE;
            end else begin
                if (r < 70) op = OP_TICK;
                else if (r < 82) op = OP_READ;
                else if (r < 92) op = OP_WAKE;
                else op = OP_NONE;
            end
            a = 1'($urandom);
            b = 1'($urandom);
            if (tidy && op == OP_TICK && !gen_count[0]) begin
                ph = gen_count[3:1];
                if (ph[0] && ph >= PH_FIRST_SAMPLE) begin
                    a = pattern[int'(ph) - int'(PH_FIRST_SAMPLE)];
                    b = pattern[int'(ph) - int'(PH_FIRST_SAMPLE) + 1];
                end
            end
            queue_item(op, a, b);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // empty read, unused operation and wake straight after reset
        queue_item(OP_READ, 1'b1, 1'b1);
        queue_item(OP_NONE, 1'b1, 1'b0);
        queue_item(OP_WAKE, 1'b0, 1'b1);
        // a full scan with every key down, then read the latches twice
        repeat (16) queue_item(OP_TICK, 1'b1, 1'b1);
        queue_item(OP_READ, 1'b0, 1'b0);
        queue_item(OP_READ, 1'b1, 1'b1);
        queue_item(OP_NONE, 1'b0, 1'b1);
        repeat (3) queue_item(OP_TICK, 1'b0, 1'b0);
        drain();

        write_settings(3'd4, 8'd0);
        queue_random(PHASE_ITEMS);
        drain();
        write_settings(3'd1, 8'd1);
        queue_random(PHASE_ITEMS);
        drain();
        write_settings(3'd7, 8'd0);
        queue_random(PHASE_ITEMS);
        drain();
        write_settings(3'd2, 8'd2);
        queue_random(PHASE_ITEMS);
        drain();
        write_settings(3'd3, 8'd255);
        queue_random(PHASE_ITEMS);
        drain();
        write_settings(3'd5, 8'd0);
        queue_random(PHASE_ITEMS);
        drain();
        write_settings(3'd0, 8'd0);
        queue_random(PHASE_ITEMS);
        drain();

        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("shift_register_key_scanner_test OK");
        end else begin
            $display("shift_register_key_scanner_test NOT OK");
        end
        $finish;
    end

endmodule

// ----- shift_register_key_scanner.f -----
rtl/core/srks_pkg.sv
rtl/core/srks_key_lane.sv
rtl/core/srks_key_merge.sv
rtl/core/srks_backlight.sv
rtl/core/shift_register_key_scanner.sv
verif/shift_register_key_scanner_test.sv
